/* sv/pse_pkg.sv */
// Shared types, codes and escape text for the packet serializer.
// No dependencies; imported by every module of the block.
package pse_pkg;

    localparam int MAX_TAG_BYTES_DEF = 8;
    localparam int QUEUE_DEPTH_DEF   = 4;

    localparam int TAG_W       = 64;
    localparam int TAG_LEN_W   = 4;
    localparam int MATCH_CNT_W = 4;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 64;
    localparam int MODE_W      = 3;
    localparam int IDX_W       = 4;

    localparam logic [TAG_W-1:0]     TAG_RESET     = 64'h0000_0000_0000_454C;
    localparam logic [TAG_LEN_W-1:0] TAG_LEN_RESET = 4'd2;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_EVIDENCE_TAG     = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_EVIDENCE_TAG_LEN = 4'd1;

    // input item modes
    localparam logic [MODE_W-1:0] MODE_HDR_BYTE   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_HDR_END    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_FIELD_BYTE = 3'd2;
    localparam logic [MODE_W-1:0] MODE_FIELD_END  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_PKT_END    = 3'd4;

    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_DOLLAR  = 8'h24;
    localparam logic [7:0] CH_AMP     = 8'h26;

    typedef enum logic [2:0] {
        CMD_BYTE    = 3'd0,
        CMD_NUM     = 3'd1,
        CMD_PERCENT = 3'd2,
        CMD_DOLLAR  = 3'd3,
        CMD_AND     = 3'd4
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] ch;
        logic       pkt_end;
    } cmd_t;

    // index of the final byte of the run for a command
    function automatic logic [IDX_W-1:0] cmd_last_idx(input cmd_kind_t kind);
        logic [IDX_W-1:0] r;
        case (kind)
            CMD_NUM:     r = 4'd4;
            CMD_PERCENT: r = 4'd8;
            CMD_DOLLAR:  r = 4'd7;
            CMD_AND:     r = 4'd4;
            default:     r = 4'd0;
        endcase
        return r;
    endfunction

    // byte idx of an escape sequence; text is left aligned in 72 bits
    function automatic logic [7:0] esc_char(input cmd_kind_t kind,
                                            input logic [IDX_W-1:0] idx);
        logic [71:0] text;
        logic [6:0]  pos;
        case (kind)
            CMD_NUM:     text = {"<num>", 32'h0};
            CMD_PERCENT: text = "<percent>";
            CMD_DOLLAR:  text = {"<dollar>", 8'h0};
            CMD_AND:     text = {"<and>", 32'h0};
            default:     text = '0;
        endcase
        pos = 7'd71 - {idx, 3'b000};
        return text[pos -: 8];
    endfunction

endpackage

/* sv/pse_queue.sv */
// Small command queue between the classifier and the byte emitter.
// Depends on pse_pkg for the command type.
module pse_queue import pse_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t wdata,
    output logic full,
    input  logic pop,
    output logic empty,
    output cmd_t rdata
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    cmd_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign rdata = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

endmodule

/* sv/pse_front.sv */
// Input side: configuration registers, header/tag comparison and
// classification of each item into an emit command. Depends on pse_pkg.
module pse_front import pse_pkg::*; #(
    parameter int MAX_TAG_BYTES = MAX_TAG_BYTES_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [MODE_W-1:0]      s_mode,
    input  logic [7:0]             s_data_char,
    input  logic                   q_full,
    output logic                   q_push,
    output cmd_t                   q_wdata
);

    logic [TAG_W-1:0]       tag_reg;
    logic [TAG_LEN_W-1:0]   tag_len_reg;
    logic [MATCH_CNT_W-1:0] match_cnt_reg, match_cnt_next;
    logic                   still_match_reg, still_match_next;
    logic                   evidence_reg, evidence_next;

    logic       accept;
    logic       len_ok;
    logic [7:0] tag_byte;
    logic       emits;

    assign cfg_ready = 1'b1;
    assign s_ready   = !q_full;
    assign accept    = s_valid && s_ready;
    assign len_ok    = (tag_len_reg <= TAG_LEN_W'(MAX_TAG_BYTES));
    assign tag_byte  = tag_reg[{match_cnt_reg[2:0], 3'b000} +: 8];

    always_comb begin
        match_cnt_next   = match_cnt_reg;
        still_match_next = still_match_reg;
        evidence_next    = evidence_reg;
        emits            = 1'b1;
        q_wdata.kind     = CMD_BYTE;
        q_wdata.ch       = s_data_char;
        q_wdata.pkt_end  = 1'b0;
        case (s_mode)
            MODE_HDR_BYTE: begin
                if (still_match_reg && len_ok &&
                    (match_cnt_reg < MATCH_CNT_W'(tag_len_reg))) begin
                    if (tag_byte == s_data_char) begin
                        match_cnt_next = match_cnt_reg + 1'b1;
                    end else begin
                        still_match_next = 1'b0;
                    end
                end else begin
                    still_match_next = 1'b0;
                end
            end
            MODE_HDR_END: begin
                evidence_next = still_match_reg && len_ok &&
                                (match_cnt_reg == MATCH_CNT_W'(tag_len_reg));
                q_wdata.ch = CH_HASH;
            end
            MODE_FIELD_BYTE: begin
                if (s_data_char == CH_HASH) begin
                    q_wdata.kind = CMD_NUM;
                end else if (s_data_char == CH_PERCENT) begin
                    q_wdata.kind = CMD_PERCENT;
                end else if (s_data_char == CH_DOLLAR) begin
                    q_wdata.kind = CMD_DOLLAR;
                end else if (s_data_char == CH_AMP && !evidence_reg) begin
                    q_wdata.kind = CMD_AND;
                end
            end
            MODE_FIELD_END: begin
                q_wdata.ch = CH_HASH;
            end
            MODE_PKT_END: begin
                q_wdata.ch       = CH_PERCENT;
                q_wdata.pkt_end  = 1'b1;
                match_cnt_next   = '0;
                still_match_next = 1'b1;
                evidence_next    = 1'b0;
            end
            default: begin
                emits = 1'b0;   // unused modes: no output, no state change
            end
        endcase
    end

    assign q_push = accept && emits;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_reg         <= TAG_RESET;
            tag_len_reg     <= TAG_LEN_RESET;
            match_cnt_reg   <= '0;
            still_match_reg <= 1'b1;
            evidence_reg    <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_EVIDENCE_TAG) begin
                    tag_reg <= cfg_data;
                end else if (cfg_index == CFG_EVIDENCE_TAG_LEN) begin
                    tag_len_reg <= cfg_data[TAG_LEN_W-1:0];
                end
            end
            if (accept) begin
                match_cnt_reg   <= match_cnt_next;
                still_match_reg <= still_match_next;
                evidence_reg    <= evidence_next;
            end
        end
    end

endmodule

/* sv/pse_back.sv */
// Output side: expands queued commands into bytes, one per cycle while
// m_ready does not stall it, into the output register. Depends on pse_pkg.
module pse_back import pse_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       q_empty,
    input  cmd_t       q_rdata,
    output logic       q_pop,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_char,
    output logic       m_last_of_run,
    output logic       m_packet_end
);

    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             m_valid_reg;
    logic [7:0]       m_out_char_reg;
    logic             m_last_reg;
    logic             m_pkt_end_reg;

    logic       load;
    logic       is_last;
    logic [7:0] ch;

    assign load    = (!m_valid_reg || m_ready) && !q_empty;
    assign is_last = (q_rdata.kind == CMD_BYTE) ||
                     (idx_reg == cmd_last_idx(q_rdata.kind));
    assign ch      = (q_rdata.kind == CMD_BYTE) ? q_rdata.ch
                                                : esc_char(q_rdata.kind, idx_reg);
    assign q_pop   = load && is_last;

    always_comb begin
        idx_next = idx_reg;
        if (load) begin
            idx_next = is_last ? '0 : idx_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            idx_reg <= idx_next;
            if (load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_out_char_reg <= ch;
            m_last_reg     <= is_last;
            m_pkt_end_reg  <= is_last && q_rdata.pkt_end;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_out_char    = m_out_char_reg;
    assign m_last_of_run = m_last_reg;
    assign m_packet_end  = m_pkt_end_reg;

endmodule

/* sv/packet_serializer_escape.sv */
// Top level of the packet serializer with field escaping.
// Depends on pse_pkg, pse_front, pse_queue and pse_back.
//
// Usage:
//  - Input channel (s_valid/s_ready, s_mode, s_data_char): one item per
//    header byte, header end, field byte, field end or packet end.
//  - Result channel (m_valid/m_ready, m_out_char, m_last_of_run,
//    m_packet_end): the serialized bytes of each item; m_last_of_run marks the
//    final byte caused by an input item, m_packet_end the closing '%'.
//  - Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): index 0 is
//    the evidence tag, index 1 its length. Always ready; write only while
//    the block is idle.
//  - Path: an accepted item is stored in the command queue; the emitter then registers each of its bytes onto m_*.
//  - Throughput: one item per cycle for items that give one byte, while
//    m_ready holds and the queue has room; an escaped field byte expands to
//    5, 8 or 9 bytes, one byte per cycle, stepped by the emitter's counter.
//  - The input keeps accepting while the result waits, until the
//    QUEUE_DEPTH command queue fills; then s_ready drops.
//  - Reset (aresetn low, synchronous) empties the queue, drops m_valid,
//    restores the tag registers and clears the header comparison.
module packet_serializer_escape import pse_pkg::*; #(
    parameter int MAX_TAG_BYTES = MAX_TAG_BYTES_DEF,
    parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [MODE_W-1:0]      s_mode,
    input  logic [7:0]             s_data_char,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [7:0]             m_out_char,
    output logic                   m_last_of_run,
    output logic                   m_packet_end
);

    logic q_push, q_pop, q_full, q_empty;
    cmd_t q_wdata, q_rdata;

    pse_front #(
        .MAX_TAG_BYTES(MAX_TAG_BYTES)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_mode      (s_mode),
        .s_data_char (s_data_char),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_wdata     (q_wdata)
    );

    pse_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wdata   (q_wdata),
        .full    (q_full),
        .pop     (q_pop),
        .empty   (q_empty),
        .rdata   (q_rdata)
    );

    pse_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_empty       (q_empty),
        .q_rdata       (q_rdata),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_char    (m_out_char),
        .m_last_of_run (m_last_of_run),
        .m_packet_end  (m_packet_end)
    );

endmodule
